[hdl/tsp_annealing_engine_macros.svh]
// Assertion macros shared by the annealing engine's checker.
// Depends on nothing; included by bare file name.
`ifndef TSP_ANNEALING_ENGINE_MACROS_SVH
`define TSP_ANNEALING_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TSPAE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TSPAE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/tspae_pkg.sv]
// Package of the annealing engine: sizes, codes, state type, random step
// and the exp(-x) lookup table. Depends on nothing.
package tspae_pkg;

  localparam int MAX_CITIES      = 64;
  localparam int CITY_BITS       = $clog2(MAX_CITIES);
  localparam int COUNT_BITS      = CITY_BITS + 1;
  localparam int DIST_ADDR_BITS  = 2 * CITY_BITS;
  localparam int DISTANCE_BITS   = 24;
  localparam int EXP_TABLE_DEPTH = 1024;
  localparam int EXP_IDX_BITS    = $clog2(EXP_TABLE_DEPTH);
  localparam int EXP_Q_BITS      = 17;
  localparam int COST_BITS       = 32;
  localparam int TEMP_BITS       = 32;
  localparam int COOL_BITS       = 16;
  localparam int MOVE_BITS       = 16;
  localparam int RAND_BITS       = 32;
  localparam int DIV_CNT_BITS    = $clog2(RAND_BITS);
  localparam int ACC_RAW_BITS    = DISTANCE_BITS + CITY_BITS + 1;
  localparam int ACC_BITS        = (ACC_RAW_BITS > COST_BITS + 1) ? ACC_RAW_BITS
                                                                  : COST_BITS + 1;
  localparam int CFG_INDEX_BITS  = 3;
  localparam int CFG_DATA_BITS   = 32;
  localparam int MIN_CITIES      = 3;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_START = 1'b1;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_CITY_COUNT,
    REG_START_TEMP,
    REG_END_TEMP,
    REG_COOLING,
    REG_MOVES,
    REG_SEED
  } cfg_reg_t;

  typedef enum logic [4:0] {
    S_IDLE, S_INIT, S_SH_DRAW, S_SH_SWAP, S_SH_NEXT, S_DIV,
    S_SW_RA, S_SW_RB, S_SW_WA, S_SW_WB,
    S_CT, S_CTW, S_CD, S_INIT_COST, S_CP_RD, S_CP_WR,
    S_LEVEL, S_MOVE_CHK, S_COOL, S_MV_A, S_MV_B, S_MV_C, S_MV_COST,
    S_MV_DEC, S_MV_ROM, S_MV_RCHK, S_MV_BEST, S_E_RD, S_E_LD
  } state_t;

  typedef logic [EXP_Q_BITS-1:0] exp_rom_t [EXP_TABLE_DEPTH];

  function automatic logic [RAND_BITS-1:0] xorshift32(input logic [RAND_BITS-1:0] x);
    logic [RAND_BITS-1:0] v;
    v = x ^ (x << 13);
    v = v ^ (v >> 17);
    v = v ^ (v << 5);
    return v;
  endfunction

  // Taylor series of e^-y on y = i/DEPTH, squared four times (e^-16y).
  function automatic logic [EXP_Q_BITS-1:0] exp_entry(input int unsigned i);
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] sum;
    int k;
    int s;
    if (i == 0) begin
      return EXP_Q_BITS'(65536);
    end
    y    = 64'(i) << (32 - EXP_IDX_BITS);
    term = 64'h1_0000_0000;
    sum  = term;
    for (k = 1; k <= 24; k++) begin
      if (term != 64'd0) begin
        term = ((term * y) >> 32) / 64'(k);
        if ((k & 1) != 0) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
    end
    if (sum > 64'hFFFF_FFFF) begin
      sum = 64'hFFFF_FFFF;
    end
    for (s = 0; s < 4; s++) begin
      sum = (sum * sum + 64'h8000_0000) >> 32;
    end
    return EXP_Q_BITS'((sum + 64'h8000) >> 16);
  endfunction

  function automatic exp_rom_t build_exp_rom();
    exp_rom_t r;
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      r[i] = exp_entry(i);
    end
    return r;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

[hdl/tspae_if.sv]
// Request and result channel interfaces of the annealing engine.
// Depends on tspae_pkg for field widths.
interface tspae_cmd_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 command;
  logic [tspae_pkg::CITY_BITS-1:0]      from_city;
  logic [tspae_pkg::CITY_BITS-1:0]      to_city;
  logic [tspae_pkg::DISTANCE_BITS-1:0]  distance;
  modport source (output valid, command, from_city, to_city, distance, input ready);
  modport sink   (input valid, command, from_city, to_city, distance, output ready);
endinterface

interface tspae_res_if;
  logic                             valid;
  logic                             ready;
  logic [tspae_pkg::CITY_BITS-1:0]  tour_position;
  logic [tspae_pkg::CITY_BITS-1:0]  city;
  logic [tspae_pkg::COST_BITS-1:0]  tour_cost;
  logic                             last;
  modport source (output valid, tour_position, city, tour_cost, last, input ready);
  modport sink   (input valid, tour_position, city, tour_cost, last, output ready);
endinterface

[hdl/tsp_annealing_engine.sv]
// Top level of the simulated annealing engine for closed TSP tours.
// Depends on tspae_pkg and the channel interfaces in tspae_if.sv.
//
//   channel  direction  handshake    payload
//   cmd      in         valid/ready  command, from_city, to_city, distance
//   result   out        valid/ready  tour_position, city, tour_cost, last
//   cfg      in         write enable cfg_index, cfg_data
//
// A load request writes one distance entry; cmd.ready is high only while idle.
// A start request runs for the whole schedule: a shuffle, then per move at
// least two random index draws, a swap, a cost sum, an exp lookup for an uphill
// move in range, a copy per new best tour; then the best tour is emitted.
// The pace is set by the shared bit-serial divider and the single read port of
// the tour and distance memories. Reset sets control and config state only.
// The result register holds a stalled result; the run waits behind it.
module tsp_annealing_engine (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_write_enable,
  input  logic [tspae_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [tspae_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  tspae_cmd_if.sink                               cmd,
  tspae_res_if.source                             result
);

  // Configuration registers.
  logic [tspae_pkg::COUNT_BITS-1:0] city_count;
  logic [tspae_pkg::TEMP_BITS-1:0]  start_temperature;
  logic [tspae_pkg::TEMP_BITS-1:0]  end_temperature;
  logic [tspae_pkg::COOL_BITS-1:0]  cooling_factor;
  logic [tspae_pkg::MOVE_BITS-1:0]  moves_per_level;
  logic [tspae_pkg::RAND_BITS-1:0]  random_seed;

  // Sequencer.
  tspae_pkg::state_t state, state_next, ret_state;

  // Run state.
  logic [tspae_pkg::RAND_BITS-1:0]  rnd;
  logic [tspae_pkg::RAND_BITS-1:0]  rnd_draw;
  logic [tspae_pkg::COUNT_BITS-1:0] n_cities;
  logic [tspae_pkg::COUNT_BITS-1:0] n_clamp;
  logic [tspae_pkg::COUNT_BITS-1:0] cnt;
  logic [tspae_pkg::CITY_BITS-1:0]  pos_i;
  logic [tspae_pkg::CITY_BITS-1:0]  pa, pb, va;
  logic [tspae_pkg::CITY_BITS-1:0]  first_city, prev_city;
  logic [tspae_pkg::ACC_BITS-1:0]   acc;
  logic                             wrap;
  logic [tspae_pkg::COST_BITS-1:0]  current_cost, best_cost, new_cost, cost_sat;
  logic [tspae_pkg::TEMP_BITS-1:0]  temperature;
  logic [tspae_pkg::MOVE_BITS-1:0]  move_cnt;
  logic [tspae_pkg::RAND_BITS/2-1:0] accept_draw;
  logic [tspae_pkg::COST_BITS-1:0]  delta;
  logic [tspae_pkg::COST_BITS+3:0]  delta16;
  logic                             too_hot;
  logic [tspae_pkg::TEMP_BITS+tspae_pkg::COOL_BITS-1:0] cool_prod;

  // Shared restoring divider: index draws (remainder) and exp index (quotient).
  logic [tspae_pkg::RAND_BITS-1:0]     div_rem, div_dsh, div_divisor;
  logic [tspae_pkg::EXP_IDX_BITS-1:0]  div_quot;
  logic [tspae_pkg::DIV_CNT_BITS-1:0]  div_cnt;
  logic [tspae_pkg::RAND_BITS:0]       div_trial, div_sub;
  logic                                div_ge;

  // Memories and their ports.
  logic [tspae_pkg::DISTANCE_BITS-1:0] dist_mem [tspae_pkg::MAX_CITIES*tspae_pkg::MAX_CITIES];
  logic [tspae_pkg::CITY_BITS-1:0]     cur_tour_mem [tspae_pkg::MAX_CITIES];
  logic [tspae_pkg::CITY_BITS-1:0]     best_tour_mem [tspae_pkg::MAX_CITIES];
  logic [tspae_pkg::DISTANCE_BITS-1:0] dist_q;
  logic [tspae_pkg::CITY_BITS-1:0]     tour_q, best_q;
  logic [tspae_pkg::EXP_Q_BITS-1:0]    rom_q;
  logic                                dist_we, tour_we, best_we;
  logic [tspae_pkg::DIST_ADDR_BITS-1:0] dist_raddr, dist_waddr;
  logic [tspae_pkg::CITY_BITS-1:0]     tour_raddr, tour_waddr, tour_wdata;
  logic [tspae_pkg::CITY_BITS-1:0]     best_raddr;

  // Result register.
  logic                             out_valid;
  logic [tspae_pkg::CITY_BITS-1:0]  out_pos, out_city;
  logic [tspae_pkg::COST_BITS-1:0]  out_cost;
  logic                             out_last;
  logic                             out_load;

  assign cmd.ready            = (state == tspae_pkg::S_IDLE);
  assign result.valid         = out_valid;
  assign result.tour_position = out_pos;
  assign result.city          = out_city;
  assign result.tour_cost     = out_cost;
  assign result.last          = out_last;

  assign rnd_draw  = tspae_pkg::xorshift32(rnd);
  assign div_trial = {div_rem, div_dsh[tspae_pkg::RAND_BITS-1]};
  assign div_ge    = (div_trial >= {1'b0, div_divisor});
  assign div_sub   = div_trial - {1'b0, div_divisor};
  assign delta     = cost_sat - current_cost;
  assign delta16   = {delta, 4'b0000};
  // An index at or past the table end means the move is rejected outright.
  assign too_hot   = (delta16 >= {4'b0000, temperature});
  assign cool_prod = temperature * cooling_factor;
  assign out_load  = (state == tspae_pkg::S_E_LD) && (!out_valid || result.ready);

  // The cost sum saturates to 32 bits.
  assign cost_sat = (|acc[tspae_pkg::ACC_BITS-1:tspae_pkg::COST_BITS])
                    ? '1 : acc[tspae_pkg::COST_BITS-1:0];

  always_comb begin
    if (city_count < tspae_pkg::COUNT_BITS'(tspae_pkg::MIN_CITIES)) begin
      n_clamp = tspae_pkg::COUNT_BITS'(tspae_pkg::MIN_CITIES);
    end else if (city_count > tspae_pkg::COUNT_BITS'(tspae_pkg::MAX_CITIES)) begin
      n_clamp = tspae_pkg::COUNT_BITS'(tspae_pkg::MAX_CITIES);
    end else begin
      n_clamp = city_count;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      tspae_pkg::S_IDLE: begin
        if (cmd.valid && cmd.command == tspae_pkg::CMD_START) begin
          state_next = tspae_pkg::S_INIT;
        end
      end
      tspae_pkg::S_INIT: begin
        if (cnt == n_cities - 1'b1) begin
          state_next = tspae_pkg::S_SH_DRAW;
        end
      end
      tspae_pkg::S_SH_DRAW:   state_next = tspae_pkg::S_DIV;
      tspae_pkg::S_DIV: begin
        if (div_cnt == '0) begin
          state_next = ret_state;
        end
      end
      tspae_pkg::S_SH_SWAP:   state_next = tspae_pkg::S_SW_RA;
      tspae_pkg::S_SW_RA:     state_next = tspae_pkg::S_SW_RB;
      tspae_pkg::S_SW_RB:     state_next = tspae_pkg::S_SW_WA;
      tspae_pkg::S_SW_WA:     state_next = tspae_pkg::S_SW_WB;
      tspae_pkg::S_SW_WB:     state_next = ret_state;
      tspae_pkg::S_SH_NEXT: begin
        if (pos_i == tspae_pkg::CITY_BITS'(1)) begin
          state_next = tspae_pkg::S_CT;
        end else begin
          state_next = tspae_pkg::S_SH_DRAW;
        end
      end
      tspae_pkg::S_CT:        state_next = tspae_pkg::S_CTW;
      tspae_pkg::S_CTW: begin
        if (cnt == '0) begin
          state_next = tspae_pkg::S_CT;
        end else begin
          state_next = tspae_pkg::S_CD;
        end
      end
      tspae_pkg::S_CD: begin
        if (wrap) begin
          state_next = ret_state;
        end else if (cnt != n_cities - 1'b1) begin
          state_next = tspae_pkg::S_CT;
        end
      end
      tspae_pkg::S_INIT_COST: state_next = tspae_pkg::S_CP_RD;
      tspae_pkg::S_CP_RD:     state_next = tspae_pkg::S_CP_WR;
      tspae_pkg::S_CP_WR: begin
        if (cnt == n_cities - 1'b1) begin
          state_next = ret_state;
        end else begin
          state_next = tspae_pkg::S_CP_RD;
        end
      end
      tspae_pkg::S_LEVEL: begin
        if (temperature > end_temperature) begin
          state_next = tspae_pkg::S_MOVE_CHK;
        end else begin
          state_next = tspae_pkg::S_E_RD;
        end
      end
      tspae_pkg::S_MOVE_CHK: begin
        if (move_cnt == moves_per_level) begin
          state_next = tspae_pkg::S_COOL;
        end else begin
          state_next = tspae_pkg::S_MV_A;
        end
      end
      tspae_pkg::S_COOL:      state_next = tspae_pkg::S_LEVEL;
      tspae_pkg::S_MV_A:      state_next = tspae_pkg::S_DIV;
      tspae_pkg::S_MV_B:      state_next = tspae_pkg::S_DIV;
      tspae_pkg::S_MV_C: begin
        if (pa == div_rem[tspae_pkg::CITY_BITS-1:0]) begin
          state_next = tspae_pkg::S_DIV;
        end else begin
          state_next = tspae_pkg::S_SW_RA;
        end
      end
      tspae_pkg::S_MV_COST:   state_next = tspae_pkg::S_CT;
      tspae_pkg::S_MV_DEC: begin
        if (cost_sat <= current_cost) begin
          state_next = tspae_pkg::S_MV_BEST;
        end else if (too_hot) begin
          state_next = tspae_pkg::S_SW_RA;
        end else begin
          state_next = tspae_pkg::S_DIV;
        end
      end
      tspae_pkg::S_MV_ROM:    state_next = tspae_pkg::S_MV_RCHK;
      tspae_pkg::S_MV_RCHK: begin
        if ({1'b0, accept_draw} < rom_q) begin
          state_next = tspae_pkg::S_MV_BEST;
        end else begin
          state_next = tspae_pkg::S_SW_RA;
        end
      end
      tspae_pkg::S_MV_BEST: begin
        if (current_cost < best_cost) begin
          state_next = tspae_pkg::S_CP_RD;
        end else begin
          state_next = tspae_pkg::S_MOVE_CHK;
        end
      end
      tspae_pkg::S_E_RD:      state_next = tspae_pkg::S_E_LD;
      tspae_pkg::S_E_LD: begin
        if (out_load) begin
          if (cnt == n_cities - 1'b1) begin
            state_next = tspae_pkg::S_IDLE;
          end else begin
            state_next = tspae_pkg::S_E_RD;
          end
        end
      end
      default:                state_next = tspae_pkg::S_IDLE;
    endcase
  end

  // Memory port controls.
  always_comb begin
    dist_we    = 1'b0;
    dist_waddr = {cmd.from_city, cmd.to_city};
    dist_raddr = {prev_city, first_city};
    tour_we    = 1'b0;
    tour_waddr = cnt[tspae_pkg::CITY_BITS-1:0];
    tour_wdata = cnt[tspae_pkg::CITY_BITS-1:0];
    tour_raddr = cnt[tspae_pkg::CITY_BITS-1:0];
    best_we    = 1'b0;
    best_raddr = cnt[tspae_pkg::CITY_BITS-1:0];
    case (state)
      tspae_pkg::S_IDLE: begin
        // Every entry addresses the table, so the range checks always pass.
        dist_we = cmd.valid && (cmd.command == tspae_pkg::CMD_LOAD)
                  && ({1'b0, cmd.from_city} < tspae_pkg::COUNT_BITS'(tspae_pkg::MAX_CITIES))
                  && ({1'b0, cmd.to_city} < tspae_pkg::COUNT_BITS'(tspae_pkg::MAX_CITIES));
      end
      tspae_pkg::S_INIT:  tour_we = 1'b1;
      tspae_pkg::S_SW_RA: tour_raddr = pa;
      tspae_pkg::S_SW_RB: tour_raddr = pb;
      tspae_pkg::S_SW_WA: begin
        tour_we    = 1'b1;
        tour_waddr = pa;
        tour_wdata = tour_q;
      end
      tspae_pkg::S_SW_WB: begin
        tour_we    = 1'b1;
        tour_waddr = pb;
        tour_wdata = va;
      end
      tspae_pkg::S_CTW:   dist_raddr = {prev_city, tour_q};
      tspae_pkg::S_CP_WR: best_we = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (dist_we) begin
      dist_mem[dist_waddr] <= cmd.distance;
    end
    dist_q <= dist_mem[dist_raddr];
  end

  always_ff @(posedge clk) begin
    if (tour_we) begin
      cur_tour_mem[tour_waddr] <= tour_wdata;
    end
    tour_q <= cur_tour_mem[tour_raddr];
  end

  always_ff @(posedge clk) begin
    if (best_we) begin
      best_tour_mem[cnt[tspae_pkg::CITY_BITS-1:0]] <= tour_q;
    end
    best_q <= best_tour_mem[best_raddr];
  end

  always_ff @(posedge clk) begin
    rom_q <= tspae_pkg::EXP_ROM[div_quot];
  end

  // Datapath and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= tspae_pkg::S_IDLE;
      out_valid         <= 1'b0;
      city_count        <= tspae_pkg::COUNT_BITS'(tspae_pkg::MAX_CITIES);
      start_temperature <= 32'd65536000;
      end_temperature   <= 32'd65536;
      cooling_factor    <= 16'd62259;
      moves_per_level   <= 16'd100;
      random_seed       <= 32'd1;
      rnd               <= 32'd1;
      current_cost      <= '0;
      best_cost         <= '0;
      temperature       <= '0;
    end else begin
      state <= state_next;

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        tspae_pkg::S_IDLE: begin
          n_cities <= n_clamp;
          cnt      <= '0;
        end
        tspae_pkg::S_INIT: begin
          cnt   <= cnt + 1'b1;
          pos_i <= cnt[tspae_pkg::CITY_BITS-1:0];
        end
        tspae_pkg::S_SH_DRAW: begin
          rnd         <= rnd_draw;
          div_dsh     <= rnd_draw;
          div_rem     <= '0;
          div_divisor <= tspae_pkg::RAND_BITS'(pos_i) + 1'b1;
          div_cnt     <= '1;
          ret_state   <= tspae_pkg::S_SH_SWAP;
        end
        tspae_pkg::S_DIV: begin
          div_rem  <= div_ge ? div_sub[tspae_pkg::RAND_BITS-1:0]
                             : div_trial[tspae_pkg::RAND_BITS-1:0];
          div_dsh  <= div_dsh << 1;
          div_quot <= {div_quot[tspae_pkg::EXP_IDX_BITS-2:0], div_ge};
          div_cnt  <= div_cnt - 1'b1;
        end
        tspae_pkg::S_SH_SWAP: begin
          pa        <= pos_i;
          pb        <= div_rem[tspae_pkg::CITY_BITS-1:0];
          ret_state <= tspae_pkg::S_SH_NEXT;
        end
        tspae_pkg::S_SW_RB: begin
          va <= tour_q;
        end
        tspae_pkg::S_SH_NEXT: begin
          pos_i     <= pos_i - 1'b1;
          cnt       <= '0;
          acc       <= '0;
          wrap      <= 1'b0;
          ret_state <= tspae_pkg::S_INIT_COST;
        end
        tspae_pkg::S_CTW: begin
          prev_city <= tour_q;
          if (cnt == '0) begin
            first_city <= tour_q;
            cnt        <= 1'b1;
          end
        end
        tspae_pkg::S_CD: begin
          acc <= acc + tspae_pkg::ACC_BITS'(dist_q);
          if (!wrap) begin
            if (cnt == n_cities - 1'b1) begin
              wrap <= 1'b1;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        tspae_pkg::S_INIT_COST: begin
          current_cost <= cost_sat;
          best_cost    <= cost_sat;
          temperature  <= start_temperature;
          cnt          <= '0;
          ret_state    <= tspae_pkg::S_LEVEL;
        end
        tspae_pkg::S_CP_WR: begin
          cnt <= cnt + 1'b1;
        end
        tspae_pkg::S_LEVEL: begin
          move_cnt <= '0;
          cnt      <= '0;
        end
        tspae_pkg::S_COOL: begin
          temperature <= cool_prod[tspae_pkg::TEMP_BITS+tspae_pkg::COOL_BITS-1:
                                   tspae_pkg::COOL_BITS];
        end
        tspae_pkg::S_MV_A, tspae_pkg::S_MV_B: begin
          if (state == tspae_pkg::S_MV_B) begin
            pa <= div_rem[tspae_pkg::CITY_BITS-1:0];
          end
          rnd         <= rnd_draw;
          div_dsh     <= rnd_draw;
          div_rem     <= '0;
          div_divisor <= tspae_pkg::RAND_BITS'(n_cities);
          div_cnt     <= '1;
          ret_state   <= (state == tspae_pkg::S_MV_A) ? tspae_pkg::S_MV_B
                                                      : tspae_pkg::S_MV_C;
        end
        tspae_pkg::S_MV_C: begin
          if (pa == div_rem[tspae_pkg::CITY_BITS-1:0]) begin
            // Equal positions: draw the second one again.
            rnd         <= rnd_draw;
            div_dsh     <= rnd_draw;
            div_rem     <= '0;
            div_divisor <= tspae_pkg::RAND_BITS'(n_cities);
            div_cnt     <= '1;
            ret_state   <= tspae_pkg::S_MV_C;
          end else begin
            pb        <= div_rem[tspae_pkg::CITY_BITS-1:0];
            ret_state <= tspae_pkg::S_MV_COST;
          end
        end
        tspae_pkg::S_MV_COST: begin
          cnt       <= '0;
          acc       <= '0;
          wrap      <= 1'b0;
          ret_state <= tspae_pkg::S_MV_DEC;
        end
        tspae_pkg::S_MV_DEC: begin
          new_cost <= cost_sat;
          if (cost_sat <= current_cost) begin
            current_cost <= cost_sat;
          end else begin
            // Uphill: the acceptance draw is taken even when the move is
            // rejected by the table range.
            rnd         <= rnd_draw;
            accept_draw <= rnd_draw[tspae_pkg::RAND_BITS-1:tspae_pkg::RAND_BITS/2];
            if (too_hot) begin
              ret_state <= tspae_pkg::S_MV_BEST;
            end else begin
              // Long division of delta*16*DEPTH by T; the starting partial
              // remainder delta*16 is already below T.
              div_rem     <= delta16[tspae_pkg::RAND_BITS-1:0];
              div_dsh     <= '0;
              div_divisor <= temperature;
              div_quot    <= '0;
              div_cnt     <= tspae_pkg::DIV_CNT_BITS'(tspae_pkg::EXP_IDX_BITS - 1);
              ret_state   <= tspae_pkg::S_MV_ROM;
            end
          end
        end
        tspae_pkg::S_MV_RCHK: begin
          if ({1'b0, accept_draw} < rom_q) begin
            current_cost <= new_cost;
          end else begin
            ret_state <= tspae_pkg::S_MV_BEST;
          end
        end
        tspae_pkg::S_MV_BEST: begin
          move_cnt  <= move_cnt + 1'b1;
          cnt       <= '0;
          ret_state <= tspae_pkg::S_MOVE_CHK;
          if (current_cost < best_cost) begin
            best_cost <= current_cost;
          end
        end
        tspae_pkg::S_E_LD: begin
          if (out_load) begin
            out_pos  <= cnt[tspae_pkg::CITY_BITS-1:0];
            out_city <= best_q;
            out_cost <= best_cost;
            out_last <= (cnt == n_cities - 1'b1);
            cnt      <= cnt + 1'b1;
          end
        end
        default: begin
        end
      endcase

      // Configuration writes must arrive only while idle; the block does not enforce it.
      if (cfg_write_enable) begin
        case (tspae_pkg::cfg_reg_t'(cfg_index))
          tspae_pkg::REG_CITY_COUNT: city_count <= cfg_data[tspae_pkg::COUNT_BITS-1:0];
          tspae_pkg::REG_START_TEMP: start_temperature <= cfg_data;
          tspae_pkg::REG_END_TEMP:   end_temperature <= cfg_data;
          tspae_pkg::REG_COOLING:    cooling_factor <= cfg_data[tspae_pkg::COOL_BITS-1:0];
          tspae_pkg::REG_MOVES:      moves_per_level <= cfg_data[tspae_pkg::MOVE_BITS-1:0];
          tspae_pkg::REG_SEED: begin
            random_seed <= cfg_data;
            rnd         <= (cfg_data == '0) ? tspae_pkg::RAND_BITS'(1) : cfg_data;
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

[hdl/tspae_checker.sv]
// Port-level checker of the annealing engine and its bind to the top level.
// Depends on tspae_pkg and tsp_annealing_engine_macros.svh.
`include "tsp_annealing_engine_macros.svh"

module tspae_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             cmd_valid,
  input logic                             cmd_ready,
  input logic                             cmd_command,
  input logic                             res_valid,
  input logic                             res_ready,
  input logic [tspae_pkg::CITY_BITS-1:0]  res_tour_position,
  input logic [tspae_pkg::CITY_BITS-1:0]  res_city,
  input logic [tspae_pkg::COST_BITS-1:0]  res_tour_cost,
  input logic                             res_last
);

  `TSPAE_ASSERT_NXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(res_city) && $stable(res_tour_cost) && $stable(res_tour_position) && $stable(res_last), "stalled result changed")
  `TSPAE_ASSERT_IMP(a_busy_mid_tour, clk, rst, res_valid && !res_last, !cmd_ready, "request taken while a tour is still being emitted")
  `TSPAE_ASSERT_NXT(a_start_busy, clk, rst, cmd_valid && cmd_ready && cmd_command == tspae_pkg::CMD_START, !cmd_ready, "engine ready right after a start request")
  `TSPAE_ASSERT_NXT(a_last_ends, clk, rst, res_valid && res_ready && res_last, !res_valid, "result follows the final city directly")

endmodule

bind tsp_annealing_engine tspae_checker u_tspae_checker (
  .clk               (clk),
  .rst               (rst),
  .cmd_valid         (cmd.valid),
  .cmd_ready         (cmd.ready),
  .cmd_command       (cmd.command),
  .res_valid         (result.valid),
  .res_ready         (result.ready),
  .res_tour_position (result.tour_position),
  .res_city          (result.city),
  .res_tour_cost     (result.tour_cost),
  .res_last          (result.last)
);
